/* rtl/core/iss_pkg.sv */
// Shared types, codes and defaults for the indexed sequence store.
`default_nettype none

package iss_pkg;

  // Default geometry
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths of the request and result
  localparam int REQ_W    = 3;
  localparam int INDEX_W  = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int LENGTH_W = 5;
  localparam int CURSOR_W = 4;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT   = 3'd0,
    REQ_DELETE   = 3'd1,
    REQ_READ_IDX = 3'd2,
    REQ_READ_CUR = 3'd3,
    REQ_NEXT     = 3'd4,
    REQ_PREV     = 3'd5,
    REQ_HOME     = 3'd6,
    REQ_TRUNCATE = 3'd7
  } req_type_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INS_SHIFT,
    S_INS_FILL,
    S_DEL_SHIFT,
    S_READ_WAIT
  } state_t;

  // Input request payload
  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
  } in_req_t;

  // Result payload
  typedef struct packed {
    logic signed [VALUE_W-1:0] read_data;
    logic [STATUS_W-1:0]       status;
    logic [LENGTH_W-1:0]       length;
    logic [CURSOR_W-1:0]       cursor_pos;
  } out_res_t;

endpackage

`default_nettype wire

/* rtl/core/iss_ram.sv */
// Entry storage: one write port, one read port, registered read data.
`default_nettype none

module iss_ram #(
  parameter int DEPTH = iss_pkg::DEPTH_DEF,
  parameter int WIDTH = iss_pkg::DATA_WIDTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data valid in the cycle after re
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/indexed_sequence_store_top.sv */
// Top level of the indexed sequence store: request sequencer around the entry RAM.
//
// Usage: an ordered list of up to DEPTH words with a cursor. A request is taken
// on in_req at a rising edge where start is high and busy is low. busy stays
// high until the request completes; then out_valid pulses for exactly one cycle
// with out_res (read data, status, length, cursor). The receiver cannot stall:
// the result must be taken in that cycle. A new request may be issued in the
// same cycle as the out_valid pulse.
// Cursor moves, home, truncate, appends and rejected requests finish in S_EXEC;
// reads wait for the registered RAM read; an insert below the tail shifts the
// later entries up and then writes the new word, and a delete at index i
// shifts the entries above i down.
// The shift of later entries moves one word per cycle through the single
// read and single write port of the entry RAM; busy stays high meanwhile, and
// a new request is taken only once the previous one has completed.
// Reset (synchronous, rst_n low) empties the list and homes the cursor; the
// RAM contents are not cleared and are never read before being written.
`default_nettype none

module indexed_sequence_store_top #(
  parameter int DEPTH      = iss_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = iss_pkg::DATA_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire iss_pkg::in_req_t in_req,
  output logic                  out_valid,
  output iss_pkg::out_res_t     out_res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > iss_pkg::INDEX_W) ? CW : iss_pkg::INDEX_W) + 1;
  localparam int SW = (DATA_WIDTH < iss_pkg::VALUE_W) ? DATA_WIDTH : iss_pkg::VALUE_W;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  iss_pkg::state_t   state_r, state_nxt;
  iss_pkg::in_req_t  req_r, req_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     cursor_r, cursor_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic              out_valid_r, out_valid_nxt;
  iss_pkg::out_res_t out_res_r, out_res_nxt;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [SW-1:0]     mem_wdata, mem_rdata;

  logic [XW-1:0]     idx_x, cnt_x, cur_x, ptr_x;

  assign idx_x = XW'(req_r.index);
  assign cnt_x = XW'(count_r);
  assign cur_x = XW'(cursor_r);
  assign ptr_x = XW'(ptr_r);

  iss_ram #(
    .DEPTH (DEPTH),
    .WIDTH (SW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Hold state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iss_pkg::S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    ptr_r     <= ptr_nxt;
    out_res_r <= out_res_nxt;
  end

  // Sequence each request: decide, shift entries, then report
  always_comb begin
    logic                    finish;
    iss_pkg::status_t        st;
    logic [SW-1:0]           rd;
    logic [XW-1:0]           cur_dec;
    logic [XW-1:0]           newcnt;

    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r;
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    finish        = 1'b0;
    st            = iss_pkg::ST_OK;
    rd            = '0;
    cur_dec       = cur_x;
    newcnt        = cnt_x;

    unique case (state_r)
      iss_pkg::S_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = iss_pkg::S_EXEC;
        end
      end

      iss_pkg::S_EXEC: begin
        unique case (iss_pkg::req_type_t'(req_r.req_type))
          iss_pkg::REQ_INSERT: begin
            if (idx_x > cnt_x) begin
              st     = iss_pkg::ST_BAD;
              finish = 1'b1;
            end else if (cnt_x >= DEPTH_X) begin
              st     = iss_pkg::ST_FULL;
              finish = 1'b1;
            end else begin
              count_nxt  = CW'(cnt_x + XW'(1));
              cursor_nxt = '0;
              if (cnt_x > idx_x) begin
                // start the upward shift at the tail
                mem_re    = 1'b1;
                mem_raddr = AW'(cnt_x - XW'(1));
                ptr_nxt   = AW'(cnt_x);
                state_nxt = iss_pkg::S_INS_SHIFT;
              end else begin
                // append: no shift needed
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_x);
                mem_wdata = req_r.value[SW-1:0];
                finish    = 1'b1;
              end
            end
          end

          iss_pkg::REQ_DELETE: begin
            if (idx_x >= cnt_x) begin
              st     = iss_pkg::ST_BAD;
              finish = 1'b1;
            end else begin
              newcnt    = cnt_x - XW'(1);
              count_nxt = CW'(newcnt);
              // keep the cursor on its entry, then clamp to the tail
              if (cur_x > idx_x) begin
                cur_dec = cur_x - XW'(1);
              end
              if (newcnt == '0) begin
                cursor_nxt = '0;
              end else if (cur_dec >= newcnt) begin
                cursor_nxt = AW'(newcnt - XW'(1));
              end else begin
                cursor_nxt = AW'(cur_dec);
              end
              if (idx_x + XW'(1) < cnt_x) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(idx_x + XW'(1));
                ptr_nxt   = AW'(idx_x);
                state_nxt = iss_pkg::S_DEL_SHIFT;
              end else begin
                finish = 1'b1;
              end
            end
          end

          iss_pkg::REQ_READ_IDX: begin
            if (idx_x >= cnt_x) begin
              st     = iss_pkg::ST_BAD;
              finish = 1'b1;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(idx_x);
              state_nxt = iss_pkg::S_READ_WAIT;
            end
          end

          iss_pkg::REQ_READ_CUR: begin
            if (cnt_x == '0 || cur_x >= cnt_x) begin
              st     = iss_pkg::ST_BAD;
              finish = 1'b1;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = cursor_r;
              state_nxt = iss_pkg::S_READ_WAIT;
            end
          end

          iss_pkg::REQ_NEXT: begin
            if (cnt_x == '0) begin
              st = iss_pkg::ST_BAD;
            end else if (cur_x + XW'(1) < cnt_x) begin
              cursor_nxt = AW'(cur_x + XW'(1));
            end
            finish = 1'b1;
          end

          iss_pkg::REQ_PREV: begin
            if (cnt_x == '0) begin
              st = iss_pkg::ST_BAD;
            end else if (cur_x != '0) begin
              cursor_nxt = AW'(cur_x - XW'(1));
            end
            finish = 1'b1;
          end

          iss_pkg::REQ_HOME: begin
            cursor_nxt = '0;
            finish     = 1'b1;
          end

          iss_pkg::REQ_TRUNCATE: begin
            if (idx_x > cnt_x) begin
              st = iss_pkg::ST_BAD;
            end else begin
              count_nxt  = CW'(idx_x);
              cursor_nxt = '0;
            end
            finish = 1'b1;
          end

          default: begin
            finish = 1'b1;
          end
        endcase
      end

      iss_pkg::S_INS_SHIFT: begin
        // move one entry up, fetch the one below
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = mem_rdata;
        if (ptr_x > idx_x + XW'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(ptr_x - XW'(2));
          ptr_nxt   = AW'(ptr_x - XW'(1));
        end else begin
          state_nxt = iss_pkg::S_INS_FILL;
        end
      end

      iss_pkg::S_INS_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_x);
        mem_wdata = req_r.value[SW-1:0];
        finish    = 1'b1;
      end

      iss_pkg::S_DEL_SHIFT: begin
        // move one entry down, fetch the next one above
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = mem_rdata;
        if (ptr_x + XW'(1) < cnt_x) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(ptr_x + XW'(2));
          ptr_nxt   = AW'(ptr_x + XW'(1));
        end else begin
          finish = 1'b1;
        end
      end

      iss_pkg::S_READ_WAIT: begin
        rd     = mem_rdata;
        finish = 1'b1;
      end

      default: begin
        state_nxt = iss_pkg::S_IDLE;
      end
    endcase

    // Report the request and return to idle
    if (finish) begin
      state_nxt              = iss_pkg::S_IDLE;
      out_valid_nxt          = 1'b1;
      out_res_nxt.read_data  = iss_pkg::VALUE_W'(rd);
      out_res_nxt.status     = st;
      out_res_nxt.length     = iss_pkg::LENGTH_W'(count_nxt);
      out_res_nxt.cursor_pos = iss_pkg::CURSOR_W'(cursor_nxt);
    end
  end

  assign busy      = (state_r != iss_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef NO_ASSERTIONS
  // Length never exceeds the storage depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(count_r) <= DEPTH_X)
    else $error("entry count above depth");

  // Cursor stays on an entry, or at the head of an empty list
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_x < cnt_x) || (count_r == '0 && cursor_r == '0))
    else $error("cursor outside the list");

  // A result appears only once the sequencer is back to idle
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // One strobe per request: no result right after an accept
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result strobe right after accept");

  // Failed requests return zero data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status != iss_pkg::ST_OK) |-> (out_res.read_data == '0))
    else $error("nonzero data on error");
`endif

endmodule

`default_nettype wire
